// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// small set of concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gqp_pkg.sv =====
// ----------------------------------------------------------------------------
// gqp_pkg
// shared types, constants and gf(2^16) arithmetic for the polynomial prg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gqp_pkg;

   localparam int unsigned NUM_GEN_DEF   = 8;
   localparam int unsigned MAX_TERMS_DEF = 8;

   localparam int unsigned GEN_W   = 3;
   localparam int unsigned SLOT_W  = 3;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TERM_W  = 4;

   // low byte of the aes reduction polynomial 0x11b
   localparam logic [7:0] GF_POLY_LO = 8'h1B;
   // y^2 + y + EXT_CONST defines the quadratic extension
   localparam logic [7:0] EXT_CONST  = 8'h20;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [GEN_W-1:0]    gen;
      logic [SLOT_W-1:0]   slot;
      logic [COEF_W-1:0]   value;
      logic [COEF_W-1:0]   x;
      logic                sel;
   } item_type;

   function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] aa;
      acc = '0;
      aa  = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ aa;
         aa = {aa[6:0], 1'b0} ^ (aa[7] ? GF_POLY_LO : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [15:0] ext_mul(input logic [15:0] a, input logic [15:0] b);
      logic [7:0] hh;
      logic [7:0] lo;
      logic [7:0] hi;
      hh = gf256_mul(a[15:8], b[15:8]);
      lo = gf256_mul(a[7:0], b[7:0]) ^ gf256_mul(EXT_CONST, hh);
      hi = gf256_mul(a[15:8], b[7:0]) ^ gf256_mul(a[7:0], b[15:8]) ^ hh;
      return {hi, lo};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gqp_bank.sv =====
// ----------------------------------------------------------------------------
// gqp_bank
// coefficient memory for one slot: one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqp_bank
   import gqp_pkg::*;
#(
   parameter int unsigned DEPTH = NUM_GEN_DEF,
   parameter int unsigned AW    = 3
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [COEF_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [COEF_W-1:0] rd_data
);

   logic [COEF_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/gqp_stage.sv =====
// ----------------------------------------------------------------------------
// gqp_stage
// one horner step: stage register, its coefficient bank and one ext multiply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gqp_stage
   import gqp_pkg::*;
#(
   parameter int unsigned NUM_GEN  = NUM_GEN_DEF,
   parameter int unsigned SLOT_IDX = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [TERM_W-1:0] term_count,
   input  wire logic              in_valid,
   input  wire item_type          in_item,
   input  wire logic [COEF_W-1:0] in_acc,
   output logic                   out_valid,
   output item_type               out_item,
   output logic      [COEF_W-1:0] out_acc
);

   localparam int unsigned AW = (NUM_GEN > 1) ? $clog2(NUM_GEN) : 1;

   logic              valid_ff;
   item_type          item_ff;
   logic [COEF_W-1:0] acc_ff;
   logic [COEF_W-1:0] coef;
   logic              wr_en;
   logic              use_coef;

   // a load writes its bank as it passes, so reads and loads stay in order
   assign wr_en = advance && in_valid && (in_item.cmd == CMD_LOAD) &&
                  (int'(in_item.gen) < int'(NUM_GEN)) &&
                  (int'(in_item.slot) == int'(SLOT_IDX));

   gqp_bank #(
      .DEPTH (NUM_GEN),
      .AW    (AW)
   ) u_bank (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(in_item.gen)),
      .wr_data (in_item.value),
      .rd_en   (advance),
      .rd_addr (AW'(in_item.gen)),
      .rd_data (coef)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= in_item;
         acc_ff  <= in_acc;
      end
   end

   // slots at or above term_count contribute nothing
   assign use_coef = int'(SLOT_IDX) < int'(term_count);

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_acc   = ext_mul(acc_ff, item_ff.x) ^ (use_coef ? coef : '0);

endmodule

`default_nettype wire

// ===== rtl/gf_quadratic_ext_poly_prg_top.sv =====
// ----------------------------------------------------------------------------
// gf_quadratic_ext_poly_prg_top
// bank of gf(2^16) polynomial prgs evaluated by a pipelined horner chain
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  command, generator, coef_slot,
//                                               coef_value, count
//   rsp       out        rsp_valid / rsp_stall  rand_byte
//   csr       in         csr_write_en           csr_write_data (term_count)
//
// one word enters per cycle while req_stall is low; a read word passes each
//   horner stage, with its gf(2^16) multiply, and then the output register
// each coefficient slot has its own bank, read once per word at its stage
// synchronous reset clears valids and sets term_count to 1; the coefficient
//   banks are not cleared and need no clearing pass
// rsp_stall holds the output word; bubbles in the chain still close up, so
//   req_stall rises only once every stage holds a word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gf_quadratic_ext_poly_prg_top
   import gqp_pkg::*;
#(
   parameter int unsigned NUM_GEN   = NUM_GEN_DEF,
   parameter int unsigned MAX_TERMS = MAX_TERMS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [GEN_W-1:0]   req_generator,
   input  wire logic [SLOT_W-1:0]  req_coef_slot,
   input  wire logic [COEF_W-1:0]  req_coef_value,
   input  wire logic [COUNT_W-1:0] req_count,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [BYTE_W-1:0]  rsp_rand_byte,
   // configuration
   input  wire logic               csr_write_en,
   input  wire logic [TERM_W-1:0]  csr_write_data
);

   // term count register
   logic [TERM_W-1:0] term_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_W'(1);
      end else if (csr_write_en) begin
         term_count_ff <= csr_write_data;
      end
   end

   // incoming word, count split into point x and byte select
   item_type req_item;

   always_comb begin
      req_item.cmd   = cmd_type'(req_command);
      req_item.gen   = req_generator;
      req_item.slot  = req_coef_slot;
      req_item.value = req_coef_value;
      req_item.x     = req_count[COUNT_W-1:1];
      req_item.sel   = req_count[0];
   end

   // horner chain: stage k handles slot MAX_TERMS-1-k
   logic              stg_valid   [MAX_TERMS];
   item_type          stg_item    [MAX_TERMS];
   logic [COEF_W-1:0] stg_acc     [MAX_TERMS];
   logic              stg_advance [MAX_TERMS];
   logic              out_advance;

   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_stage
      logic              up_valid;
      item_type          up_item;
      logic [COEF_W-1:0] up_acc;

      if (k == 0) begin : g_head
         assign up_valid = req_valid;
         assign up_item  = req_item;
         assign up_acc   = '0;
      end else begin : g_body
         assign up_valid = stg_valid[k-1];
         assign up_item  = stg_item[k-1];
         assign up_acc   = stg_acc[k-1];
      end

      // a stage takes a new word when empty or when its word moves on
      if (k == MAX_TERMS - 1) begin : g_last
         assign stg_advance[k] = !stg_valid[k] || out_advance;
      end else begin : g_mid
         assign stg_advance[k] = !stg_valid[k] || stg_advance[k+1];
      end

      gqp_stage #(
         .NUM_GEN  (NUM_GEN),
         .SLOT_IDX (MAX_TERMS - 1 - k)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (stg_advance[k]),
         .term_count (term_count_ff),
         .in_valid   (up_valid),
         .in_item    (up_item),
         .in_acc     (up_acc),
         .out_valid  (stg_valid[k]),
         .out_item   (stg_item[k]),
         .out_acc    (stg_acc[k])
      );
   end

   assign req_stall = !stg_advance[0];

   // output register: loads retire here without a word
   logic              last_valid;
   item_type          last_item;
   logic [COEF_W-1:0] last_acc;
   logic              last_gen_ok;
   logic              last_is_read;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [BYTE_W-1:0] rsp_byte_in;

   assign last_valid   = stg_valid[MAX_TERMS-1];
   assign last_item    = stg_item[MAX_TERMS-1];
   assign last_acc     = stg_acc[MAX_TERMS-1];
   assign last_gen_ok  = int'(last_item.gen) < int'(NUM_GEN);
   assign last_is_read = last_valid && (last_item.cmd == CMD_READ);

   assign out_advance  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = last_is_read;

   always_comb begin
      if (!last_gen_ok) begin
         // unknown generator reads as zero
         rsp_byte_in = '0;
      end else if (last_item.sel) begin
         rsp_byte_in = last_acc[15:8];
      end else begin
         rsp_byte_in = last_acc[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance) rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rand_byte = rsp_byte_ff;

   // checks
   logic load_retire;
   logic read_retire;
   logic bad_gen_retire;

   assign load_retire    = out_advance && last_valid && (last_item.cmd == CMD_LOAD);
   assign read_retire    = out_advance && last_is_read;
   assign bad_gen_retire = read_retire && !last_gen_ok;

   `ASSERT_IMPLIES(a_stall_only_full, clock, reset, req_stall, stg_valid[0], "stall with empty head stage")
   `ASSERT_NEXT(a_load_no_word, clock, reset, load_retire, !rsp_valid, "load produced a word")
   `ASSERT_NEXT(a_read_gives_word, clock, reset, read_retire, rsp_valid, "read word lost")
   `ASSERT_NEXT(a_bad_gen_zero, clock, reset, bad_gen_retire, rsp_rand_byte == '0, "bad generator nonzero")

endmodule

`default_nettype wire
